// ----- src/b64d_pkg.sv -----
`timescale 1ns / 1ps
package b64d_pkg;

  localparam int CHAR_W     = 8;
  localparam int VAL_W      = 6;
  localparam int COUNT_W    = 13;
  localparam int STATUS_W   = 2;
  localparam int ACC_W      = 12;
  localparam int PEND_W     = 4;
  localparam int OUT_DATA_W = 24;

  localparam int MAX_BYTES_DEF  = 4096;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam logic [COUNT_W-1:0] CAP_RESET = 13'd4096;

  // func codes on the input tuser
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CHR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVER    = 2'd3;

  // classified word handed from front to back
  typedef struct packed {
    logic             is_end;
    logic             bad;
    logic [VAL_W-1:0] val;
  } b64d_entry_t;

  localparam int ENTRY_W = $bits(b64d_entry_t);

endpackage

// ----- src/b64d_front.sv -----
`timescale 1ns / 1ps
module b64d_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [b64d_pkg::CHAR_W-1:0]      in_tdata,
  input  logic                             in_tuser,
  input  logic                             q_full,
  output logic                             q_push,
  output b64d_pkg::b64d_entry_t            q_entry
);

  logic [b64d_pkg::CHAR_W-1:0] c;
  logic [b64d_pkg::CHAR_W-1:0] v8;
  logic                        bad;

  assign c = in_tdata;

  // alphabet map: A-Z 0..25, a-z 26..51, 0-9 52..61, '-' 62, '_' 63
  always_comb begin
    bad = 1'b0;
    v8  = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      v8 = c - 8'h41;
    end else if (c inside {[8'h61:8'h7A]}) begin
      v8 = c - 8'h61 + 8'd26;
    end else if (c inside {[8'h30:8'h39]}) begin
      v8 = c - 8'h30 + 8'd52;
    end else if (c == 8'h2D) begin
      v8 = 8'd62;
    end else if (c == 8'h5F) begin
      v8 = 8'd63;
    end else begin
      bad = 1'b1;
    end
  end

  assign in_tready      = !q_full;
  assign q_push         = in_tvalid && !q_full;
  assign q_entry.is_end = (in_tuser == b64d_pkg::FUNC_END);
  assign q_entry.bad    = bad;
  assign q_entry.val    = v8[b64d_pkg::VAL_W-1:0];

endmodule

// ----- src/b64d_fifo.sv -----
`timescale 1ns / 1ps
module b64d_fifo #(
  parameter int DEPTH = b64d_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  b64d_pkg::b64d_entry_t       push_entry,
  output logic                        full,
  input  logic                        pop,
  output logic                        empty,
  output b64d_pkg::b64d_entry_t       head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64d_pkg::b64d_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- src/b64d_back.sv -----
`timescale 1ns / 1ps
module b64d_back #(
  parameter int MAX_BYTES = b64d_pkg::MAX_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [b64d_pkg::COUNT_W-1:0]      cfg_wdata,
  input  logic                              q_empty,
  input  b64d_pkg::b64d_entry_t             q_head,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [b64d_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser
);

  localparam int CW = b64d_pkg::COUNT_W;
  localparam logic [CW-1:0] CAP_LIMIT =
    (MAX_BYTES >= (1 << CW)) ? {CW{1'b1}} : CW'(MAX_BYTES);

  logic [CW-1:0]                   cap_r;
  logic [b64d_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic [b64d_pkg::PEND_W-1:0]     pend_r, pend_nxt, pend_sum;
  logic [1:0]                      phase_r, phase_nxt;
  logic [CW-1:0]                   bytes_r, bytes_nxt;
  logic [b64d_pkg::STATUS_W-1:0]   err_r, err_nxt;
  logic                            ovalid_r, ovalid_nxt;
  logic                            ouser_r, ouser_nxt;
  logic [b64d_pkg::OUT_DATA_W-1:0] odata_r, odata_nxt;
  logic [CW-1:0]                   cap_eff;
  logic [b64d_pkg::ACC_W-1:0]      acc_shift;
  logic [b64d_pkg::STATUS_W-1:0]   st;
  logic                            advance;

  assign cap_eff  = (cap_r > CAP_LIMIT) ? CAP_LIMIT : cap_r;
  assign advance  = !ovalid_r || out_tready;
  assign q_pop    = advance && !q_empty;
  assign pend_sum = pend_r + 4'd6;

  always_comb begin
    acc_nxt    = acc_r;
    pend_nxt   = pend_r;
    phase_nxt  = phase_r;
    bytes_nxt  = bytes_r;
    err_nxt    = err_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ouser_nxt  = ouser_r;
    odata_nxt  = odata_r;
    acc_shift  = '0;
    st         = err_r;
    if (q_pop) begin
      if (q_head.is_end) begin
        st         = (phase_r == 2'd1) ? b64d_pkg::ST_BAD_LEN : err_r;
        ovalid_nxt = 1'b1;
        ouser_nxt  = 1'b1;
        odata_nxt  = {1'b0, bytes_r, st, 8'h00};
        acc_nxt    = '0;
        pend_nxt   = '0;
        phase_nxt  = '0;
        bytes_nxt  = '0;
        err_nxt    = b64d_pkg::ST_OK;
      end else begin
        phase_nxt = phase_r + 2'd1;
        if (err_r == b64d_pkg::ST_OK) begin
          if (q_head.bad) begin
            err_nxt = b64d_pkg::ST_BAD_CHR;
          end else begin
            acc_nxt = {acc_r[5:0], q_head.val};
            if (pend_sum >= 4'd8) begin
              pend_nxt = pend_sum - 4'd8;
              if (bytes_r >= cap_eff) begin
                err_nxt = b64d_pkg::ST_OVER;
              end else begin
                acc_shift  = acc_nxt >> pend_nxt;
                ovalid_nxt = 1'b1;
                ouser_nxt  = 1'b0;
                odata_nxt  = {16'h0000, acc_shift[7:0]};
                bytes_nxt  = bytes_r + 1'b1;
              end
            end else begin
              pend_nxt = pend_sum;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= b64d_pkg::CAP_RESET;
      acc_r    <= '0;
      pend_r   <= '0;
      phase_r  <= '0;
      bytes_r  <= '0;
      err_r    <= b64d_pkg::ST_OK;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      acc_r    <= acc_nxt;
      pend_r   <= pend_nxt;
      phase_r  <= phase_nxt;
      bytes_r  <= bytes_nxt;
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ouser_r <= ouser_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ouser_r;
  assign out_tdata  = odata_r;

endmodule

// ----- src/base64url_stream_decoder_top.sv -----
`timescale 1ns / 1ps
// Unpadded base64url decoder. Send one character per word (in_tuser = 0) and
// close each string with an end word (in_tuser = 1). Each completed byte comes
// out at once as a data word (out_tuser = 0); the end word yields one status
// word (out_tuser = 1) with the code (0 ok, 1 bad character, 2 bad length,
// 3 over capacity) and the number of bytes sent for that string. After the
// first error a string sends no more bytes; drop its earlier bytes when the
// status is not ok. Trailing bits are not checked. The byte limit is the
// smaller of cfg_wdata (reset 4096) and MAX_BYTES; write it only while idle.
// Throughput is one word per cycle while the output is not stalled: a small
// classifier at the input writes a short queue, and the decode stage pops one
// entry per cycle into the output register. The queue memory is registered.
module base64url_stream_decoder_top #(
  parameter int MAX_BYTES  = b64d_pkg::MAX_BYTES_DEF,
  parameter int FIFO_DEPTH = b64d_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config: byte limit
  input  logic                              cfg_we,
  input  logic [b64d_pkg::COUNT_W-1:0]      cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [b64d_pkg::CHAR_W-1:0]      in_tdata,   // [7:0] char_code
  input  logic                              in_tuser,   // [0] func
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] data_byte, [9:8] status_code, [22:10] byte_count, [23] zero
  output logic [b64d_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser   // [0] is_status
);

  b64d_pkg::b64d_entry_t push_entry;
  b64d_pkg::b64d_entry_t head;
  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  empty;

  // front: handshake and character classification
  b64d_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  // decouples the input from output stalls
  b64d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  // back: bit accumulator, counters, error tracking, output register
  b64d_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_empty    (empty),
    .q_head     (head),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- bench/base64url_stream_decoder_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the base64url stream decoder.
// - Strings are queued as words by the stimulus block; a clocked driver offers them.
// - Every accepted input word runs through a local decoder model.
// - The model queues the data or status word the block should return.
// - A clocked monitor pops that queue on each accepted output word.
// - It then compares the output field by field.
module base64url_stream_decoder_top_test;
  import b64d_pkg::*;

  localparam int RUN_LIMIT   = 100000;  // cycles
  localparam int LONG_HOLD   = 400;     // receiver hold-off, cycles
  localparam int SETTLE_CYC  = 16;      // > fifo depth + pipeline, covers no-result words
  localparam int NO_CHAR     = 64;      // sextet lookup miss

  // input word: func in tuser, char byte in tdata
  typedef struct packed {
    logic              func;
    logic [CHAR_W-1:0] code;
  } char_word_t;

  // output word split into its fields
  typedef struct packed {
    logic                is_status;
    logic [7:0]          data_byte;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } dec_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [COUNT_W-1:0]    cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata = '0;   // [7:0] char_code
  logic                  in_tuser = 1'b0; // [0] func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [7:0] byte, [9:8] status, [22:10] count
  logic                  out_tuser;       // [0] is_status

  base64url_stream_decoder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  char_word_t pending_chars[$];   // words still to be offered
  dec_word_t  expected_words[$];  // words the block owes us
  int         errors = 0;
  int         cycles = 0;
  int         idle_pct = 38;      // chance (%) that a side idles in a cycle
  int         stall_reqs = 0;     // bumped by stimulus to ask for a long hold-off
  int         stalls_done = 0;

  // decoder model state
  logic [COUNT_W-1:0]  cap_reg = CAP_RESET;
  logic [ACC_W-1:0]    acc_bits = '0;
  logic [PEND_W-1:0]   acc_fill = '0;
  logic [1:0]          char_phase = '0;
  logic [COUNT_W-1:0]  bytes_sent = '0;
  logic [STATUS_W-1:0] first_err = ST_OK;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // base64url alphabet lookup, NO_CHAR when outside it
  function automatic int sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "-") return 62;
    if (c == "_") return 63;
    return NO_CHAR;
  endfunction

  function automatic logic [7:0] char_of(input int v);
    if (v < 26) return 8'(int'("A") + v);
    if (v < 52) return 8'(int'("a") + v - 26);
    if (v < 62) return 8'(int'("0") + v - 52);
    if (v == 62) return "-";
    return "_";
  endfunction

  // Model one accepted input word; queue the word it should produce, if any.
  task automatic decode_char_word(input char_word_t w);
    logic [COUNT_W-1:0] limit;
    dec_word_t r;
    int v;
    limit = (cap_reg > COUNT_W'(MAX_BYTES_DEF)) ? COUNT_W'(MAX_BYTES_DEF) : cap_reg;
    r = '0;
    if (w.func == FUNC_END) begin
      // length is judged before any recorded error
      r.is_status = 1'b1;
      r.status    = (char_phase == 2'd1) ? ST_BAD_LEN : first_err;
      r.count     = bytes_sent;
      expected_words.push_back(r);
      acc_bits   = '0;
      acc_fill   = '0;
      char_phase = '0;
      bytes_sent = '0;
      first_err  = ST_OK;
    end else begin
      char_phase = char_phase + 2'd1;
      if (first_err == ST_OK) begin
        v = sextet_of(w.code);
        if (v == NO_CHAR) begin
          first_err = ST_BAD_CHR;
        end else begin
          acc_bits = {acc_bits[ACC_W-7:0], 6'(v)};
          acc_fill = acc_fill + 4'd6;
          if (acc_fill >= 4'd8) begin
            acc_fill = acc_fill - 4'd8;
            if (bytes_sent >= limit) begin
              first_err = ST_OVER;
            end else begin
              r.data_byte = 8'(acc_bits >> acc_fill);
              expected_words.push_back(r);
              bytes_sent = bytes_sent + 1'b1;
            end
          end
        end
      end
    end
  endtask

  // Driver: an offer that is not taken stays put; otherwise maybe start the next.
  always @(posedge clk) begin : drive
    char_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_char_word('{in_tuser, in_tdata});
      end
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_chars.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.func;
          in_tdata  <= nxt.code;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted output word, then pick next cycle's tready.
  always @(posedge clk) begin : watch
    dec_word_t got, want;
    int hold_left;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[7:0], out_tdata[9:8], out_tdata[22:10]};
        if (out_tdata[23] !== 1'b0)
          flag_error("pad bit of out_tdata not zero");
        if (expected_words.size() == 0) begin
          flag_error($sformatf("unexpected word %h", got));
        end else begin
          want = expected_words.pop_front();
          if (got.is_status !== want.is_status)
            flag_error($sformatf("is_status %b, want %b", got.is_status, want.is_status));
          if (got.data_byte !== want.data_byte)
            flag_error($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
          if (got.status !== want.status)
            flag_error($sformatf("status_code %0d, want %0d", got.status, want.status));
          if (got.count !== want.count)
            flag_error($sformatf("byte_count %0d, want %0d", got.count, want.count));
        end
      end
      if (stall_reqs != stalls_done) begin
        hold_left   = LONG_HOLD;
        stalls_done = stall_reqs;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_char(input logic [7:0] c);
    pending_chars.push_back('{FUNC_CHAR, c});
  endtask

  // end word; the char byte is don't-care so it is randomized
  task automatic push_end();
    pending_chars.push_back('{FUNC_END, 8'($urandom_range(255))});
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_char(s[i]);
    push_end();
  endtask

  function automatic logic [7:0] bad_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (sextet_of(b) != NO_CHAR);
    return b;
  endfunction

  // One random string: mostly well formed, some bad length, bad chars or noise.
  task automatic push_random_string(output int n_words);
    int kind, len, bad_at;
    kind = $urandom_range(99);
    len  = $urandom_range(24);
    if (kind < 70 && len % 4 == 1) len++;
    if (kind >= 70 && kind < 80) len = 4 * $urandom_range(5) + 1;
    bad_at = (len == 0) ? 0 : $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      if (kind >= 92)
        push_char(8'($urandom_range(255)));
      else if (kind >= 80 && i == bad_at)
        push_char(bad_char());
      else
        push_char(char_of($urandom_range(63)));
    end
    push_end();
    n_words = len + 1;
  endtask

  task automatic push_random_words(input int target);
    int added, n;
    added = 0;
    while (added < target) begin
      push_random_string(n);
      added += n;
    end
  endtask

  // Sender pause: wait until all words are in and every result is back,
  // then let no-result words still in flight drain.
  task automatic wait_idle();
    do @(posedge clk); while (pending_chars.size() != 0 || in_tvalid || expected_words.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cap(input logic [COUNT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_reg    = v;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset capacity
    push_end();                     // empty string
    push_text("A");                 // one char: bad length
    push_text("_-9z");              // alphabet edges, three bytes
    push_text("QU=B");              // '=' is a bad char, later chars still counted
    push_text("=");                 // bad char and bad length: length wins
    push_text("QUJ");               // trailing bits left unchecked
    push_char(8'h00);
    push_char(8'hFF);
    push_end();
    wait_idle();

    // zero capacity: first completed byte overflows
    write_cap(13'd0);
    push_text("AAAA");
    push_random_words(40);
    wait_idle();

    // above MAX_BYTES: clamps; receiver holds off so the input stalls
    write_cap(13'd8191);
    push_random_words(180);
    stall_reqs++;
    wait_idle();

    write_cap(13'd1);
    push_random_words(100);
    wait_idle();

    // long stretch with no idling on either side
    write_cap(13'd5);
    idle_pct = 0;
    push_random_words(150);
    wait_idle();
    idle_pct = 38;

    write_cap(CAP_RESET);
    push_random_words(200);
    wait_idle();

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
